>>> src/hps_pkg.sv
// ----------------------------------------------------------------------------
// hps_pkg: shared definitions for the haptic pattern sequencer
// Command codes, message kinds, control word layout and the sequencer program.
// ----------------------------------------------------------------------------
`default_nettype none

package hps_pkg;

    // Motor-driver command codes
    localparam logic [2:0] ACT_STOP      = 3'd0;
    localparam logic [2:0] ACT_INTTRIG   = 3'd1;
    localparam logic [2:0] ACT_LIBRARY   = 3'd2;
    localparam logic [2:0] ACT_SLOT      = 3'd3;
    localparam logic [2:0] ACT_GO        = 3'd4;
    localparam logic [2:0] ACT_REALTIME  = 3'd5;
    localparam logic [2:0] ACT_AMPLITUDE = 3'd6;

    // Message kinds
    localparam logic [1:0] KIND_IGNORE   = 2'd0;
    localparam logic [1:0] KIND_WAVEFORM = 2'd1;
    localparam logic [1:0] KIND_PATTERN  = 2'd2;

    // Type byte values
    localparam logic [7:0] TYPE_WAVEFORM = 8'd0;
    localparam logic [7:0] TYPE_PATTERN  = 8'd1;

    // Library number sent with the select-library command
    localparam logic [7:0] LIBRARY_NUM = 8'd1;

    // Value source
    localparam logic [1:0] VAL_ZERO = 2'd0;
    localparam logic [1:0] VAL_ONE  = 2'd1;
    localparam logic [1:0] VAL_WAVE = 2'd2;
    localparam logic [1:0] VAL_PAT  = 2'd3;

    // Last-beat select
    localparam logic [1:0] LAST_NEVER   = 2'd0;
    localparam logic [1:0] LAST_ALWAYS  = 2'd1;
    localparam logic [1:0] LAST_IF_DONE = 2'd2;

    // Jump conditions
    localparam logic [2:0] JC_NONE        = 3'd0;
    localparam logic [2:0] JC_NO_WAVE     = 3'd1;
    localparam logic [2:0] JC_SLOT_MORE   = 3'd2;
    localparam logic [2:0] JC_NO_PAT      = 3'd3;
    localparam logic [2:0] JC_NOT_PLAYING = 3'd4;
    localparam logic [2:0] JC_NO_ADV      = 3'd5;
    localparam logic [2:0] JC_PAST_LEN    = 3'd6;
    localparam logic [2:0] JC_DELAY_ZERO  = 3'd7;

    // Datapath operations
    localparam logic [3:0] OP_NONE      = 4'd0;
    localparam logic [3:0] OP_SLOT_CLR  = 4'd1;
    localparam logic [3:0] OP_SLOT_INC  = 4'd2;
    localparam logic [3:0] OP_WAVE_CLR  = 4'd3;
    localparam logic [3:0] OP_PAT_START = 4'd4;
    localparam logic [3:0] OP_TIMER     = 4'd5;
    localparam logic [3:0] OP_DELAY_LD  = 4'd6;
    localparam logic [3:0] OP_AMP       = 4'd7;
    localparam logic [3:0] OP_STOP_PLAY = 4'd8;

    // Pattern read address select
    localparam logic ADDR_NEXT  = 1'b0;
    localparam logic ADDR_NEXT1 = 1'b1;

    localparam int PC_W = 5;

    // Program entry points
    localparam logic [PC_W-1:0] P_START   = 5'd0;
    localparam logic [PC_W-1:0] P_SLOT_RD = 5'd4;
    localparam logic [PC_W-1:0] P_PAT     = 5'd8;
    localparam logic [PC_W-1:0] P_PLAY    = 5'd11;
    localparam logic [PC_W-1:0] P_STOP    = 5'd17;
    localparam logic [PC_W-1:0] P_END     = 5'd20;

    typedef struct packed {
        logic            emit;
        logic [2:0]      action;
        logic [1:0]      val_sel;
        logic [1:0]      last_sel;
        logic [2:0]      jcond;
        logic [PC_W-1:0] target;
        logic [3:0]      op;
        logic            addr_sel;
        logic            fin;
    } ctrl_t;

    function automatic ctrl_t emit_word(logic [2:0] act, logic [1:0] vs,
                                        logic [1:0] ls, logic [3:0] op);
        ctrl_t c;
        c          = '0;
        c.emit     = 1'b1;
        c.action   = act;
        c.val_sel  = vs;
        c.last_sel = ls;
        c.op       = op;
        return c;
    endfunction

    function automatic ctrl_t jump_word(logic [2:0] jc, logic [PC_W-1:0] tgt);
        ctrl_t c;
        c        = '0;
        c.jcond  = jc;
        c.target = tgt;
        return c;
    endfunction

    // Tick program: waveform burst, sequence start, then one playback step.
    function automatic ctrl_t ucode(logic [PC_W-1:0] pc);
        ctrl_t c;
        c = '0;
        case (pc)
            5'd0:  c = jump_word(JC_NO_WAVE, P_PAT);
            5'd1:  c = emit_word(ACT_STOP, VAL_ZERO, LAST_NEVER, OP_NONE);
            5'd2:  c = emit_word(ACT_INTTRIG, VAL_ZERO, LAST_NEVER, OP_NONE);
            5'd3:  c = emit_word(ACT_LIBRARY, VAL_ONE, LAST_NEVER, OP_SLOT_CLR);
            5'd4:  c = '0;  // wait for slot read data
            5'd5:  c = emit_word(ACT_SLOT, VAL_WAVE, LAST_NEVER, OP_SLOT_INC);
            5'd6:  c = jump_word(JC_SLOT_MORE, P_SLOT_RD);
            5'd7:  c = emit_word(ACT_GO, VAL_ZERO, LAST_IF_DONE, OP_WAVE_CLR);
            5'd8:  c = jump_word(JC_NO_PAT, P_PLAY);
            5'd9:  c = emit_word(ACT_STOP, VAL_ZERO, LAST_NEVER, OP_NONE);
            5'd10: c = emit_word(ACT_REALTIME, VAL_ZERO, LAST_NEVER, OP_PAT_START);
            5'd11: c = jump_word(JC_NOT_PLAYING, P_END);
            5'd12: c.op = OP_TIMER;
            5'd13: c = jump_word(JC_NO_ADV, P_END);
            5'd14: begin
                c          = jump_word(JC_PAST_LEN, P_STOP);
                c.addr_sel = ADDR_NEXT1;
            end
            5'd15: begin
                c.op       = OP_DELAY_LD;
                c.addr_sel = ADDR_NEXT;
            end
            5'd16: begin
                c          = emit_word(ACT_AMPLITUDE, VAL_PAT, LAST_ALWAYS, OP_AMP);
                c.jcond    = JC_DELAY_ZERO;
                c.target   = P_STOP;
                c.addr_sel = ADDR_NEXT;
                c.fin      = 1'b1;
            end
            5'd17: c = emit_word(ACT_STOP, VAL_ZERO, LAST_NEVER, OP_NONE);
            5'd18: c = emit_word(ACT_INTTRIG, VAL_ZERO, LAST_NEVER, OP_NONE);
            5'd19: begin
                c     = emit_word(ACT_LIBRARY, VAL_ONE, LAST_ALWAYS, OP_STOP_PLAY);
                c.fin = 1'b1;
            end
            5'd20: c.fin = 1'b1;
            default: c.fin = 1'b1;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

>>> src/haptic_pattern_sequencer.sv
// ----------------------------------------------------------------------------
// haptic_pattern_sequencer: message-driven haptic motor command sequencer
// Stores waveform and amplitude/delay messages, plays them out on ticks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_*): one beat is either a message byte (s_cmd = 0) or a
//   one-millisecond tick (s_cmd = 1). s_first_byte marks the type byte of a
//   new message. A message byte does not lower s_ready; only a tick does.
//   A tick starts the control program: a small ROM of control words stepped
//   by a program counter, with conditional jumps. Each emitting step sends one
//   motor-driver command beat on the m_* channel; m_last_result marks the last
//   command of the tick. s_ready stays low until the program finishes.
//   A tick with nothing to do only runs its checks; a waveform burst adds
//   its setup beats, a read, an emit and a jump per slot through the
//   registered RAM, and its go beat; a sequence start and a playback step
//   follow where needed. A burst's first beat comes from the step after the check.
//   The program stalls on an emitting step while the output register holds
//   a beat and m_ready is low; a new beat loads as the old one is taken, so
//   no cycle is lost when m_ready stays high.
//   Reset (aresetn low, synchronous) clears counts, pending flags and
//   playback; stored bytes are only read below the received counts.
// ----------------------------------------------------------------------------
`default_nettype none

module haptic_pattern_sequencer #(
    parameter int WAVEFORM_SLOTS       = 8,
    parameter int PATTERN_BYTES        = 20,
    parameter int TICKS_PER_DELAY_UNIT = 10
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,

    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic       s_cmd,
    input  wire logic       s_first_byte,
    input  wire logic [7:0] s_byte_value,

    output logic            m_valid,
    input  wire logic       m_ready,
    output logic      [2:0] m_action,
    output logic      [2:0] m_slot,
    output logic      [7:0] m_value,
    output logic            m_last_result
);

    // Widths follow the capacities
    localparam int SC_W   = $clog2(WAVEFORM_SLOTS + 1);
    localparam int WA_W   = (WAVEFORM_SLOTS > 1) ? $clog2(WAVEFORM_SLOTS) : 1;
    localparam int PA_W   = $clog2(PATTERN_BYTES);
    localparam int LEN_W  = $clog2(PATTERN_BYTES + 1);
    localparam int PI_W   = $clog2(PATTERN_BYTES + 3);
    localparam int HOLD_W = $clog2(255 * TICKS_PER_DELAY_UNIT + 1);
    localparam int PC_W   = hps_pkg::PC_W;

    localparam logic [SC_W-1:0]   SLOTS_K = SC_W'(WAVEFORM_SLOTS);
    localparam logic [LEN_W-1:0]  BYTES_K = LEN_W'(PATTERN_BYTES);
    localparam logic [HOLD_W-1:0] TICKS_K = HOLD_W'(TICKS_PER_DELAY_UNIT);

    // Sequencer control
    logic              busy_reg, busy_next;
    logic [PC_W-1:0]   pc_reg, pc_next;
    hps_pkg::ctrl_t    ctrl;
    logic              jump_take;
    logic              out_free;
    logic              step_done;
    logic              emit_fire;
    logic              in_fire;
    logic              more_after_go;

    // Message state
    logic [1:0]        kind_reg, kind_next;
    logic [SC_W-1:0]   wcount_reg, wcount_next;
    logic [LEN_W-1:0]  plen_reg, plen_next;
    logic              wpend_reg, wpend_next;
    logic              ppend_reg, ppend_next;

    // Playback state
    logic              playing_reg, playing_next;
    logic              ns_reg, ns_next;
    logic [PI_W-1:0]   pos_reg, pos_next;
    logic [HOLD_W-1:0] hold_reg, hold_next;

    // Datapath scratch
    logic [SC_W-1:0]   slot_reg, slot_next;
    logic [PI_W-1:0]   nxt_reg, nxt_next;
    logic [PI_W-1:0]   nxt1;
    logic              adv_reg, adv_next;
    logic [7:0]        delay_reg, delay_next;

    // Output register
    logic              m_valid_reg, m_valid_next;
    logic [2:0]        m_action_reg, m_action_next;
    logic [2:0]        m_slot_reg, m_slot_next;
    logic [7:0]        m_value_reg, m_value_next;
    logic              m_last_reg, m_last_next;

    // Stores
    logic              wave_we, pat_we;
    logic [7:0]        wave_rdata, pat_rdata;
    logic [PA_W-1:0]   pat_raddr;

    assign s_ready       = !busy_reg;
    assign m_valid       = m_valid_reg;
    assign m_action      = m_action_reg;
    assign m_slot        = m_slot_reg;
    assign m_value       = m_value_reg;
    assign m_last_result = m_last_reg;

    assign in_fire  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign nxt1     = nxt_reg + PI_W'(1);
    assign ctrl     = hps_pkg::ucode(pc_reg);

    // Store byte writes only while idle
    assign wave_we = in_fire && !s_cmd && !s_first_byte
                     && (kind_reg == hps_pkg::KIND_WAVEFORM) && (wcount_reg < SLOTS_K);
    assign pat_we  = in_fire && !s_cmd && !s_first_byte
                     && (kind_reg == hps_pkg::KIND_PATTERN) && (plen_reg < BYTES_K);

    assign pat_raddr = (ctrl.addr_sel == hps_pkg::ADDR_NEXT1) ? PA_W'(nxt1) : PA_W'(nxt_reg);

    hps_ram #(
        .WIDTH  (8),
        .DEPTH  (WAVEFORM_SLOTS),
        .ADDR_W (WA_W)
    ) u_wave_ram (
        .aclk  (aclk),
        .we    (wave_we),
        .waddr (WA_W'(wcount_reg)),
        .wdata (s_byte_value),
        .raddr (WA_W'(slot_reg)),
        .rdata (wave_rdata)
    );

    hps_ram #(
        .WIDTH  (8),
        .DEPTH  (PATTERN_BYTES),
        .ADDR_W (PA_W)
    ) u_pat_ram (
        .aclk  (aclk),
        .we    (pat_we),
        .waddr (PA_W'(plen_reg)),
        .wdata (s_byte_value),
        .raddr (pat_raddr),
        .rdata (pat_rdata)
    );

    // Something still follows the go beat in this tick
    assign more_after_go = ppend_reg
                           || (playing_reg && (ns_reg || (hold_reg <= HOLD_W'(1))));

    // Jump condition decode
    always_comb begin
        case (ctrl.jcond)
            hps_pkg::JC_NONE:        jump_take = 1'b0;
            hps_pkg::JC_NO_WAVE:     jump_take = !wpend_reg;
            hps_pkg::JC_SLOT_MORE:   jump_take = (slot_reg != SLOTS_K);
            hps_pkg::JC_NO_PAT:      jump_take = !ppend_reg;
            hps_pkg::JC_NOT_PLAYING: jump_take = !playing_reg;
            hps_pkg::JC_NO_ADV:      jump_take = !adv_reg;
            hps_pkg::JC_PAST_LEN:    jump_take = (nxt_reg >= PI_W'(plen_reg));
            hps_pkg::JC_DELAY_ZERO:  jump_take = (delay_reg == 8'd0);
            default:                 jump_take = 1'b0;
        endcase
    end

    // A step completes when it does not jump and, if it emits, the output
    // register can take the beat
    assign step_done = busy_reg && !jump_take && (!ctrl.emit || out_free);
    assign emit_fire = step_done && ctrl.emit;

    always_comb begin
        busy_next     = busy_reg;
        pc_next       = pc_reg;
        kind_next     = kind_reg;
        wcount_next   = wcount_reg;
        plen_next     = plen_reg;
        wpend_next    = wpend_reg;
        ppend_next    = ppend_reg;
        playing_next  = playing_reg;
        ns_next       = ns_reg;
        pos_next      = pos_reg;
        hold_next     = hold_reg;
        slot_next     = slot_reg;
        nxt_next      = nxt_reg;
        adv_next      = adv_reg;
        delay_next    = delay_reg;
        m_valid_next  = m_valid_reg;
        m_action_next = m_action_reg;
        m_slot_next   = m_slot_reg;
        m_value_next  = m_value_reg;
        m_last_next   = m_last_reg;

        // Input beats: bytes update message state, ticks start the program
        if (in_fire) begin
            if (s_cmd) begin
                busy_next = 1'b1;
                pc_next   = hps_pkg::P_START;
            end else if (s_first_byte) begin
                if (s_byte_value == hps_pkg::TYPE_WAVEFORM) begin
                    kind_next   = hps_pkg::KIND_WAVEFORM;
                    wcount_next = '0;
                    wpend_next  = 1'b1;
                end else if (s_byte_value == hps_pkg::TYPE_PATTERN) begin
                    kind_next = hps_pkg::KIND_PATTERN;
                    plen_next = '0;
                end else begin
                    kind_next = hps_pkg::KIND_IGNORE;
                end
            end else if (kind_reg == hps_pkg::KIND_WAVEFORM) begin
                if (wcount_reg < SLOTS_K) begin
                    wcount_next = wcount_reg + SC_W'(1);
                end
            end else if (kind_reg == hps_pkg::KIND_PATTERN) begin
                if (plen_reg < BYTES_K) begin
                    plen_next = plen_reg + LEN_W'(1);
                end
                ppend_next = 1'b1;
            end
        end

        // Program step
        if (busy_reg) begin
            if (jump_take) begin
                pc_next = ctrl.target;
            end else if (step_done) begin
                case (ctrl.op)
                    hps_pkg::OP_NONE: begin
                    end
                    hps_pkg::OP_SLOT_CLR:  slot_next = '0;
                    hps_pkg::OP_SLOT_INC:  slot_next = slot_reg + SC_W'(1);
                    hps_pkg::OP_WAVE_CLR:  wpend_next = 1'b0;
                    hps_pkg::OP_PAT_START: begin
                        playing_next = 1'b1;
                        ns_next      = 1'b1;
                        ppend_next   = 1'b0;
                    end
                    hps_pkg::OP_TIMER: begin
                        // Count the hold down; advance on start or at expiry
                        if (!ns_reg && (hold_reg != '0)) begin
                            hold_next = hold_reg - HOLD_W'(1);
                        end
                        adv_next = ns_reg || (hold_reg <= HOLD_W'(1));
                        nxt_next = ns_reg ? '0 : (pos_reg + PI_W'(2));
                    end
                    hps_pkg::OP_DELAY_LD: begin
                        delay_next = (nxt1 < PI_W'(plen_reg)) ? pat_rdata : 8'd0;
                    end
                    hps_pkg::OP_AMP: begin
                        pos_next  = nxt_reg;
                        ns_next   = 1'b0;
                        hold_next = HOLD_W'({{(HOLD_W-8){1'b0}}, delay_reg} * TICKS_K);
                    end
                    hps_pkg::OP_STOP_PLAY: playing_next = 1'b0;
                    default: begin
                    end
                endcase
                if (ctrl.fin) begin
                    busy_next = 1'b0;
                end else begin
                    pc_next = pc_reg + PC_W'(1);
                end
            end
        end

        // Output register: load a beat or drain the taken one
        if (emit_fire) begin
            m_valid_next  = 1'b1;
            m_action_next = ctrl.action;
            m_slot_next   = (ctrl.val_sel == hps_pkg::VAL_WAVE) ? 3'(slot_reg) : 3'd0;
            case (ctrl.val_sel)
                hps_pkg::VAL_ZERO: m_value_next = 8'd0;
                hps_pkg::VAL_ONE:  m_value_next = hps_pkg::LIBRARY_NUM;
                hps_pkg::VAL_WAVE: m_value_next = (slot_reg < wcount_reg) ? wave_rdata : 8'd0;
                hps_pkg::VAL_PAT:  m_value_next = pat_rdata;
                default:           m_value_next = 8'd0;
            endcase
            case (ctrl.last_sel)
                hps_pkg::LAST_NEVER:   m_last_next = 1'b0;
                hps_pkg::LAST_ALWAYS:  m_last_next = 1'b1;
                hps_pkg::LAST_IF_DONE: m_last_next = !more_after_go;
                default:               m_last_next = 1'b0;
            endcase
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            pc_reg      <= hps_pkg::P_START;
            kind_reg    <= hps_pkg::KIND_IGNORE;
            wcount_reg  <= '0;
            plen_reg    <= '0;
            wpend_reg   <= 1'b0;
            ppend_reg   <= 1'b0;
            playing_reg <= 1'b0;
            ns_reg      <= 1'b1;
            pos_reg     <= '0;
            hold_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            pc_reg      <= pc_next;
            kind_reg    <= kind_next;
            wcount_reg  <= wcount_next;
            plen_reg    <= plen_next;
            wpend_reg   <= wpend_next;
            ppend_reg   <= ppend_next;
            playing_reg <= playing_next;
            ns_reg      <= ns_next;
            pos_reg     <= pos_next;
            hold_reg    <= hold_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath and payload
    always_ff @(posedge aclk) begin
        slot_reg     <= slot_next;
        nxt_reg      <= nxt_next;
        adv_reg      <= adv_next;
        delay_reg    <= delay_next;
        m_action_reg <= m_action_next;
        m_slot_reg   <= m_slot_next;
        m_value_reg  <= m_value_next;
        m_last_reg   <= m_last_next;
    end

    // A finished tick leaves nothing pending
    a_tick_clears_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(busy_reg) |-> (!wpend_reg && !ppend_reg))
        else $error("pending flag left set after tick program");

    // Stores are written only while the program is idle
    a_no_write_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (!wave_we && !pat_we))
        else $error("store write during tick program");

    // Playback always starts from the first pair
    a_play_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(playing_reg) |-> ns_reg)
        else $error("playback started without start flag");

endmodule

`default_nettype wire

>>> src/hps_ram.sv
// ----------------------------------------------------------------------------
// hps_ram: simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hps_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 8,
    parameter int ADDR_W = 3
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
